[hw/rtl/mseu_pkg.sv]
// shared types and constants of the mips subset execute unit
`timescale 1ns / 1ps
package mseu_pkg;

    typedef enum logic [5:0] {
        F_ADD     = 6'd0,
        F_ADDU    = 6'd1,
        F_SUB     = 6'd2,
        F_AND     = 6'd3,
        F_OR      = 6'd4,
        F_XOR     = 6'd5,
        F_NOR     = 6'd6,
        F_NAND    = 6'd7,
        F_SLT     = 6'd8,
        F_SLL     = 6'd9,
        F_SRL     = 6'd10,
        F_SRA     = 6'd11,
        F_JR      = 6'd12,
        F_MULT    = 6'd13,
        F_MULTU   = 6'd14,
        F_MFHI    = 6'd15,
        F_MFLO    = 6'd16,
        F_ADDI    = 6'd17,
        F_ADDIU   = 6'd18,
        F_LW      = 6'd19,
        F_LH      = 6'd20,
        F_LHU     = 6'd21,
        F_LB      = 6'd22,
        F_LBU     = 6'd23,
        F_SW      = 6'd24,
        F_SH      = 6'd25,
        F_SB      = 6'd26,
        F_LUI     = 6'd27,
        F_ANDI    = 6'd28,
        F_ORI     = 6'd29,
        F_NORI    = 6'd30,
        F_SLTI    = 6'd31,
        F_BEQ     = 6'd32,
        F_BNE     = 6'd33,
        F_BGTZ    = 6'd34,
        F_J       = 6'd35,
        F_JAL     = 6'd36,
        F_PRELOAD = 6'd37
    } t_func;

    localparam int CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] CFG_START_PC = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_INIT_SP  = 2'd1;

    localparam logic [4:0]  REG_ZERO = 5'd0;
    localparam logic [4:0]  REG_SP   = 5'd29;
    localparam logic [4:0]  REG_RA   = 5'd31;
    localparam logic [31:0] SP_RESET = 32'd1024;
    localparam logic [31:0] PC_RESET = 32'd0;
    localparam logic [31:0] SEG_MASK = 32'hF000_0000;

    // one classified instruction between front and back
    typedef struct packed {
        t_func       func;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  dest;
        logic        wr;
        logic [31:0] imm;
        logic [31:0] pdata;
    } t_uop;

    typedef struct packed {
        logic               valid;
        logic [CfgIdxW-1:0] idx;
        logic [31:0]        data;
    } t_cfg_wr;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_write;
        logic [4:0]  reg_number;
        logic [31:0] reg_value;
        logic        hilo_write;
        logic [31:0] hi_value;
        logic [31:0] lo_value;
        logic        mem_read;
        logic        mem_store;
        logic [31:0] mem_address;
    } t_result;

endpackage

[hw/rtl/mseu_front.sv]
// front end: request intake, destination classification and two-entry queue
`timescale 1ns / 1ps
module mseu_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [5:0]       i_func,
    input  logic [4:0]       i_rs_index,
    input  logic [4:0]       i_rt_index,
    input  logic [4:0]       i_rd_index,
    input  logic [31:0]      i_immediate,
    input  logic [31:0]      i_preload_data,
    input  logic             i_busy,
    output logic             o_q_valid,
    output mseu_pkg::t_uop   o_q_uop,
    input  logic             i_q_pop
);
    import mseu_pkg::*;

    t_func      dec_func;
    logic [4:0] dec_dest;
    logic       dec_wkind;
    t_uop       dec_uop;
    logic       push;

    t_uop       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_comb begin
        dec_func = t_func'(i_func);
        case (dec_func) inside
            [F_ADD:F_SRA], F_MFHI, F_MFLO: begin
                dec_dest  = i_rd_index;
                dec_wkind = 1'b1;
            end
            [F_ADDI:F_LBU], [F_LUI:F_SLTI]: begin
                dec_dest  = i_rt_index;
                dec_wkind = 1'b1;
            end
            F_JAL: begin
                dec_dest  = REG_RA;
                dec_wkind = 1'b1;
            end
            default: begin
                dec_dest  = REG_ZERO;
                dec_wkind = 1'b0;
            end
        endcase
        dec_uop.func  = dec_func;
        dec_uop.rs    = i_rs_index;
        dec_uop.rt    = i_rt_index;
        // writes to register zero are dropped here
        dec_uop.wr    = dec_wkind && (dec_dest != REG_ZERO);
        dec_uop.dest  = dec_uop.wr ? dec_dest : REG_ZERO;
        dec_uop.imm   = i_immediate;
        dec_uop.pdata = i_preload_data;
    end

    assign o_in_ready = (r_cnt != 2'd2) && !i_busy;
    assign push       = i_in_valid && o_in_ready;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_uop    = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= dec_uop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end

endmodule

[hw/rtl/mseu_back.sv]
// back end: operand read, execute, data memory and result register
`timescale 1ns / 1ps
module mseu_back #(
    parameter int DATA_MEM_BYTES = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  mseu_pkg::t_uop    i_q_uop,
    output logic              o_q_pop,
    input  mseu_pkg::t_cfg_wr i_cfg,
    output logic              o_busy,
    output logic              o_valid,
    input  logic              i_ready,
    output mseu_pkg::t_result o_res
);
    import mseu_pkg::*;

    localparam int Words = DATA_MEM_BYTES / 4;
    localparam int MAW   = $clog2(DATA_MEM_BYTES);
    localparam int WAW   = MAW - 2;
    localparam logic [WAW-1:0] LastWord = WAW'(Words - 1);

    typedef struct packed {
        logic        wr;
        logic [4:0]  dest;
        logic [31:0] val;
        t_func       func;
        logic [1:0]  off;
        logic        mrd;
        logic        mst;
        logic [31:0] addr;
        logic [31:0] npc;
        logic        hilo;
    } t_e3;

    logic             adv;
    logic [31:0]      r_rf [32];
    logic [31:0]      r_rf_vld;
    logic [31:0]      r_rfa;
    logic [31:0]      r_rfb;
    logic             r_rfa_v;
    logic             r_rfb_v;
    logic             r_e2_v;
    t_uop             r_e2;
    logic             r_e3_v;
    t_e3              r_e3;
    logic             r_wb_v;
    logic [4:0]       r_wb_dest;
    logic [31:0]      r_wb_val;
    logic             r_out_v;
    t_result          r_out;
    logic [31:0]      r_pc;
    logic [31:0]      r_hi;
    logic [31:0]      r_lo;
    logic             r_clr_busy;
    logic [WAW-1:0]   r_clr_cnt;
    logic [3:0][7:0]  r_mem [Words];
    logic [3:0][7:0]  r_mrd;

    logic [31:0]      rf_a;
    logic [31:0]      rf_b;
    logic [31:0]      op_a;
    logic [31:0]      op_b;
    logic [31:0]      e3_val;
    logic [15:0]      ld_half;
    logic [7:0]       ld_byte;
    logic [31:0]      pc4;
    logic [31:0]      ea;
    logic [31:0]      btarget;
    logic [31:0]      jtarget;
    logic [4:0]       sh;
    logic             is_mult;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;
    t_e3              n_e3;
    logic             is_load;
    logic             is_wmem;
    logic             e2_go;
    logic             rf_we;
    logic [4:0]       rf_wa;
    logic [31:0]      rf_wd;
    logic             m_re;
    logic [3:0]       m_be;
    logic [WAW-1:0]   m_wa;
    logic [3:0][7:0]  m_wd;
    logic [31:0]      st_addr;
    logic             cfg_sp;

    assign adv     = !r_out_v || i_ready;
    assign o_q_pop = adv && i_q_valid && !r_clr_busy;
    assign o_busy  = r_clr_busy;
    assign o_valid = r_out_v;
    assign o_res   = r_out;
    assign e2_go   = adv && r_e2_v;
    assign cfg_sp  = i_cfg.valid && (i_cfg.idx == CFG_INIT_SP);

    // operand bypass: youngest write first
    always_comb begin
        rf_a = r_rfa_v ? r_rfa : ((r_e2.rs == REG_SP) ? SP_RESET : 32'd0);
        rf_b = r_rfb_v ? r_rfb : ((r_e2.rt == REG_SP) ? SP_RESET : 32'd0);
        if (r_e3_v && r_e3.wr && (r_e3.dest == r_e2.rs)) begin
            op_a = e3_val;
        end else if (r_wb_v && (r_wb_dest == r_e2.rs)) begin
            op_a = r_wb_val;
        end else begin
            op_a = rf_a;
        end
        if (r_e3_v && r_e3.wr && (r_e3.dest == r_e2.rt)) begin
            op_b = e3_val;
        end else if (r_wb_v && (r_wb_dest == r_e2.rt)) begin
            op_b = r_wb_val;
        end else begin
            op_b = rf_b;
        end
    end

    // execute
    always_comb begin
        pc4     = r_pc + 32'd4;
        ea      = op_a + r_e2.imm;
        btarget = pc4 + {r_e2.imm[29:0], 2'b00};
        jtarget = (pc4 & SEG_MASK) | {r_e2.imm[29:0], 2'b00};
        sh      = r_e2.imm[4:0];
        is_mult = (r_e2.func == F_MULT);
        mul_a   = {is_mult & op_a[31], op_a};
        mul_b   = {is_mult & op_b[31], op_b};
        mul_p   = mul_a * mul_b;
        is_load = 1'b0;
        is_wmem = 1'b0;

        n_e3      = '0;
        n_e3.wr   = r_e2.wr;
        n_e3.dest = r_e2.dest;
        n_e3.func = r_e2.func;
        n_e3.off  = ea[1:0];
        n_e3.npc  = pc4;
        case (r_e2.func)
            F_ADD, F_ADDU: n_e3.val = op_a + op_b;
            F_SUB:         n_e3.val = op_a - op_b;
            F_AND:         n_e3.val = op_a & op_b;
            F_OR:          n_e3.val = op_a | op_b;
            F_XOR:         n_e3.val = op_a ^ op_b;
            F_NOR:         n_e3.val = ~(op_a | op_b);
            F_NAND:        n_e3.val = ~(op_a & op_b);
            F_SLT:         n_e3.val = {31'd0, $signed(op_a) < $signed(op_b)};
            F_SLL:         n_e3.val = op_b << sh;
            F_SRL:         n_e3.val = op_b >> sh;
            F_SRA:         n_e3.val = 32'($signed(op_b) >>> sh);
            F_JR:          n_e3.npc = op_a;
            F_MULT, F_MULTU: n_e3.hilo = 1'b1;
            F_MFHI:        n_e3.val = r_hi;
            F_MFLO:        n_e3.val = r_lo;
            F_ADDI, F_ADDIU: n_e3.val = op_a + r_e2.imm;
            F_LW, F_LH, F_LHU, F_LB, F_LBU: begin
                is_load  = 1'b1;
                n_e3.mrd = 1'b1;
            end
            F_SW, F_SH, F_SB: begin
                is_wmem  = 1'b1;
                n_e3.mst = 1'b1;
            end
            F_LUI:         n_e3.val = {r_e2.imm[15:0], 16'd0};
            F_ANDI:        n_e3.val = op_a & r_e2.imm;
            F_ORI:         n_e3.val = op_a | r_e2.imm;
            F_NORI:        n_e3.val = ~(op_a | r_e2.imm);
            F_SLTI:        n_e3.val = {31'd0, $signed(op_a) < $signed(r_e2.imm)};
            F_BEQ:         n_e3.npc = (op_a == op_b) ? btarget : pc4;
            F_BNE:         n_e3.npc = (op_a != op_b) ? btarget : pc4;
            F_BGTZ:        n_e3.npc = ((op_a != 32'd0) && !op_a[31]) ? btarget : pc4;
            F_J:           n_e3.npc = jtarget;
            F_JAL: begin
                n_e3.npc = jtarget;
                n_e3.val = pc4;
            end
            F_PRELOAD: begin
                is_wmem  = 1'b1;
                n_e3.npc = r_pc;
            end
            default: n_e3.npc = pc4;
        endcase
        if (!r_e2.wr) begin
            n_e3.val = 32'd0;
        end
        n_e3.addr = (n_e3.mrd || n_e3.mst) ? ea : 32'd0;
    end

    // data memory port: clearing pass, then stores and preloads
    always_comb begin
        st_addr = (r_e2.func == F_PRELOAD) ? r_e2.imm : ea;
        m_re    = e2_go && is_load;
        m_wa    = st_addr[MAW-1:2];
        case (r_e2.func)
            F_SH: begin
                m_wd = {op_b[15:0], op_b[15:0]};
                m_be = st_addr[1] ? 4'b0011 : 4'b1100;
            end
            F_SB: begin
                m_wd = {4{op_b[7:0]}};
                case (st_addr[1:0])
                    2'd0:    m_be = 4'b1000;
                    2'd1:    m_be = 4'b0100;
                    2'd2:    m_be = 4'b0010;
                    default: m_be = 4'b0001;
                endcase
            end
            F_PRELOAD: begin
                m_wd = r_e2.pdata;
                m_be = 4'b1111;
            end
            default: begin
                m_wd = op_b;
                m_be = 4'b1111;
            end
        endcase
        if (!(e2_go && is_wmem)) begin
            m_be = 4'b0000;
        end
        if (r_clr_busy) begin
            m_wa = r_clr_cnt;
            m_wd = '0;
            m_be = 4'b1111;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 4; l++) begin
            if (m_be[l]) begin
                r_mem[m_wa][l] <= m_wd[l];
            end
        end
        if (m_re) begin
            r_mrd <= r_mem[ea[MAW-1:2]];
        end
    end

    // load alignment, big-endian
    always_comb begin
        ld_half = r_e3.off[1] ? r_mrd[1:0] : r_mrd[3:2];
        case (r_e3.off)
            2'd0:    ld_byte = r_mrd[3];
            2'd1:    ld_byte = r_mrd[2];
            2'd2:    ld_byte = r_mrd[1];
            default: ld_byte = r_mrd[0];
        endcase
        case (r_e3.func)
            F_LW:    e3_val = r_mrd;
            F_LH:    e3_val = {{16{ld_half[15]}}, ld_half};
            F_LHU:   e3_val = {16'd0, ld_half};
            F_LB:    e3_val = {{24{ld_byte[7]}}, ld_byte};
            F_LBU:   e3_val = {24'd0, ld_byte};
            default: e3_val = r_e3.val;
        endcase
        if (!r_e3.wr) begin
            e3_val = 32'd0;
        end
    end

    // register file port
    always_comb begin
        rf_we = adv && r_e3_v && r_e3.wr;
        rf_wa = r_e3.dest;
        rf_wd = e3_val;
        if (cfg_sp) begin
            rf_we = 1'b1;
            rf_wa = REG_SP;
            rf_wd = i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf[rf_wa] <= rf_wd;
        end
        if (o_q_pop) begin
            r_rfa <= r_rf[i_q_uop.rs];
            r_rfb <= r_rf[i_q_uop.rt];
            r_e2  <= i_q_uop;
        end
        if (adv) begin
            r_e3      <= n_e3;
            r_wb_dest <= r_e3.dest;
            r_wb_val  <= e3_val;
            r_out.next_pc     <= r_e3.npc;
            r_out.reg_write   <= r_e3.wr;
            r_out.reg_number  <= r_e3.dest;
            r_out.reg_value   <= e3_val;
            r_out.hilo_write  <= r_e3.hilo;
            r_out.hi_value    <= r_hi;
            r_out.lo_value    <= r_lo;
            r_out.mem_read    <= r_e3.mrd;
            r_out.mem_store   <= r_e3.mst;
            r_out.mem_address <= r_e3.addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld   <= '0;
            r_rfa_v    <= 1'b0;
            r_rfb_v    <= 1'b0;
            r_e2_v     <= 1'b0;
            r_e3_v     <= 1'b0;
            r_wb_v     <= 1'b0;
            r_out_v    <= 1'b0;
            r_pc       <= PC_RESET;
            r_hi       <= 32'd0;
            r_lo       <= 32'd0;
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == LastWord) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (rf_we) begin
                r_rf_vld[rf_wa] <= 1'b1;
            end
            if (o_q_pop) begin
                r_rfa_v <= r_rf_vld[i_q_uop.rs];
                r_rfb_v <= r_rf_vld[i_q_uop.rt];
            end
            if (adv) begin
                r_e2_v  <= o_q_pop;
                r_e3_v  <= r_e2_v;
                r_out_v <= r_e3_v;
            end
            // stack pointer load replaces the pending write-back bypass value
            if (cfg_sp) begin
                r_wb_v <= 1'b0;
            end else if (adv) begin
                r_wb_v <= r_e3_v && r_e3.wr;
            end
            if (i_cfg.valid && (i_cfg.idx == CFG_START_PC)) begin
                r_pc <= i_cfg.data;
            end else if (e2_go) begin
                r_pc <= n_e3.npc;
            end
            if (e2_go && n_e3.hilo) begin
                r_hi <= mul_p[63:32];
                r_lo <= mul_p[31:0];
            end
        end
    end

`ifndef SYNTHESIS
    a_no_pop_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !o_q_pop)
        else $error("instruction issued during memory clear");
    a_no_zero_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rf_we |-> (rf_wa != REG_ZERO))
        else $error("register zero written");
    a_e3_dest_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e3_v && r_e3.wr) |-> (r_e3.dest != REG_ZERO))
        else $error("write flagged for register zero");
    a_ld_st_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e3_v |-> !(r_e3.mrd && r_e3.mst))
        else $error("load and store in one instruction");
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_ready) |=> ($stable(r_out) && r_out_v && $stable(r_pc)))
        else $error("state moved while result stalled");
`endif

endmodule

[hw/rtl/mips_subset_execute_unit.sv]
// top level of the mips subset execute unit
`timescale 1ns / 1ps
// usage
//   s channel: one decoded instruction per request (func, register numbers,
//     extended immediate, preload word). m channel: one result per request,
//     in order, with next pc, register write, hi/lo and memory access info.
//   cfg channel: index 0 loads the program counter, index 1 loads register
//     29; write it only while no request is in flight. cfg_ready is always 1.
// throughput
//   a request passes the queue, e2, e3 and the result register; one
//   request per cycle is sustained while m_tready is high. a two-entry
//   queue separates the decode front from the execute back; operand bypass
//   covers back-to-back dependencies, including a load followed by its use.
// reset
//   synchronous, active low. pc = 0, register 29 = 1024, all else zero.
//   the data memory is then cleared one word per cycle, DATA_MEM_BYTES/4
//   words, with s_tready low; cfg writes are taken during that pass.
// stall
//   when m_tready is low the result is held and the back end freezes; the
//   queue keeps accepting until both entries are full.
// DATA_MEM_BYTES must be a power of two; addresses wrap to that size.
module mips_subset_execute_unit #(
    parameter int DATA_MEM_BYTES = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // func[5:0], rs_index[10:6], rt_index[15:11], rd_index[20:16],
    // immediate[52:21], preload_data[84:53], zero[87:85]
    input  logic [87:0]  i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // next_pc[31:0], reg_number[36:32], reg_value[68:37], hi_value[100:69],
    // lo_value[132:101], mem_address[164:133], zero[167:165]
    output logic [167:0] o_m_tdata,
    // reg_write[0], hilo_write[1], mem_read[2], mem_store[3]
    output logic [3:0]   o_m_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    import mseu_pkg::*;

    logic    busy;
    logic    q_valid;
    t_uop    q_uop;
    logic    q_pop;
    t_cfg_wr cfg;
    t_result res;

    assign o_cfg_ready = 1'b1;
    assign cfg.valid   = i_cfg_valid;
    assign cfg.idx     = i_cfg_index;
    assign cfg.data    = i_cfg_data;

    mseu_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_s_tvalid),
        .o_in_ready     (o_s_tready),
        .i_func         (i_s_tdata[5:0]),
        .i_rs_index     (i_s_tdata[10:6]),
        .i_rt_index     (i_s_tdata[15:11]),
        .i_rd_index     (i_s_tdata[20:16]),
        .i_immediate    (i_s_tdata[52:21]),
        .i_preload_data (i_s_tdata[84:53]),
        .i_busy         (busy),
        .o_q_valid      (q_valid),
        .o_q_uop        (q_uop),
        .i_q_pop        (q_pop)
    );

    mseu_back #(
        .DATA_MEM_BYTES (DATA_MEM_BYTES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_uop   (q_uop),
        .o_q_pop   (q_pop),
        .i_cfg     (cfg),
        .o_busy    (busy),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_res     (res)
    );

    // result packing, first field lowest
    assign o_m_tdata = {3'd0, res.mem_address, res.lo_value, res.hi_value,
                        res.reg_value, res.reg_number, res.next_pc};
    assign o_m_tuser = {res.mem_store, res.mem_read, res.hilo_write, res.reg_write};

endmodule

[test/mips_subset_execute_unit_chk.sv]
// result checker for the mips subset execute unit: predicts and compares results
`timescale 1ns / 1ps
module mips_subset_execute_unit_chk (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [87:0]  i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [167:0] i_m_tdata,
    input  logic [3:0]   i_m_tuser,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    output int           o_mismatch_count,
    output int           o_waiting_count,
    output int           o_result_count
);
    import mseu_pkg::*;

    logic [31:0] gpr [32];
    logic [31:0] hi_q, lo_q, pc_q;
    logic [7:0]  dmem [1024];
    t_result     expected_results [$];

    function automatic logic [31:0] ld_word(logic [31:0] addr);
        logic [31:0] b;
        b = addr & ~32'd3;
        return {dmem[b[9:0]], dmem[(b + 1) % 1024], dmem[(b + 2) % 1024],
                dmem[(b + 3) % 1024]};
    endfunction

    task automatic st_word(input logic [31:0] addr, input logic [31:0] v);
        logic [31:0] b;
        b = addr & ~32'd3;
        dmem[b[9:0]]      = v[31:24];
        dmem[(b + 1) % 1024] = v[23:16];
        dmem[(b + 2) % 1024] = v[15:8];
        dmem[(b + 3) % 1024] = v[7:0];
    endtask

    // executes one instruction on the shadow state
    task automatic execute(input logic [87:0] d, output t_result r);
        logic [5:0]  f;
        logic [31:0] a, b, imm, pdata, pc4, npc, addr, val, bt, h;
        logic [4:0]  dest, sh;
        logic        wr, hl, mrd, mst;
        logic signed [63:0] sp;
        logic [63:0] up;
        f = d[5:0];
        a = gpr[d[10:6]];
        b = gpr[d[15:11]];
        imm = d[52:21];
        pdata = d[84:53];
        sh = imm[4:0];
        pc4 = pc_q + 4;
        npc = pc4;
        addr = a + imm;
        bt = pc4 + (imm << 2);
        dest = 0; val = 0; wr = 0; hl = 0; mrd = 0; mst = 0;
        case (f)
            F_ADD, F_ADDU: begin dest = d[20:16]; val = a + b; wr = 1; end
            F_SUB:  begin dest = d[20:16]; val = a - b; wr = 1; end
            F_AND:  begin dest = d[20:16]; val = a & b; wr = 1; end
            F_OR:   begin dest = d[20:16]; val = a | b; wr = 1; end
            F_XOR:  begin dest = d[20:16]; val = a ^ b; wr = 1; end
            F_NOR:  begin dest = d[20:16]; val = ~(a | b); wr = 1; end
            F_NAND: begin dest = d[20:16]; val = ~(a & b); wr = 1; end
            F_SLT:  begin dest = d[20:16]; val = {31'd0, $signed(a) < $signed(b)}; wr = 1; end
            F_SLL:  begin dest = d[20:16]; val = b << sh; wr = 1; end
            F_SRL:  begin dest = d[20:16]; val = b >> sh; wr = 1; end
            F_SRA:  begin dest = d[20:16]; val = $signed(b) >>> sh; wr = 1; end
            F_JR:   npc = a;
            F_MULT: begin
                sp = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                {hi_q, lo_q} = sp; hl = 1;
            end
            F_MULTU: begin
                up = {32'd0, a} * {32'd0, b};
                {hi_q, lo_q} = up; hl = 1;
            end
            F_MFHI: begin dest = d[20:16]; val = hi_q; wr = 1; end
            F_MFLO: begin dest = d[20:16]; val = lo_q; wr = 1; end
            F_ADDI, F_ADDIU: begin dest = d[15:11]; val = a + imm; wr = 1; end
            F_LW:  begin dest = d[15:11]; val = ld_word(addr); wr = 1; mrd = 1; end
            F_LH, F_LHU: begin
                h = addr & ~32'd1;
                val = {16'd0, dmem[h[9:0]], dmem[(h + 1) % 1024]};
                if (f == F_LH && val[15]) val[31:16] = 16'hFFFF;
                dest = d[15:11]; wr = 1; mrd = 1;
            end
            F_LB, F_LBU: begin
                val = {24'd0, dmem[addr[9:0]]};
                if (f == F_LB && val[7]) val[31:8] = 24'hFFFFFF;
                dest = d[15:11]; wr = 1; mrd = 1;
            end
            F_SW: begin st_word(addr, b); mst = 1; end
            F_SH: begin
                h = addr & ~32'd1;
                dmem[h[9:0]] = b[15:8];
                dmem[(h + 1) % 1024] = b[7:0];
                mst = 1;
            end
            F_SB:   begin dmem[addr[9:0]] = b[7:0]; mst = 1; end
            F_LUI:  begin dest = d[15:11]; val = imm << 16; wr = 1; end
            F_ANDI: begin dest = d[15:11]; val = a & imm; wr = 1; end
            F_ORI:  begin dest = d[15:11]; val = a | imm; wr = 1; end
            F_NORI: begin dest = d[15:11]; val = ~(a | imm); wr = 1; end
            F_SLTI: begin dest = d[15:11]; val = {31'd0, $signed(a) < $signed(imm)}; wr = 1; end
            F_BEQ:  if (a == b) npc = bt;
            F_BNE:  if (a != b) npc = bt;
            F_BGTZ: if (a != 0 && !a[31]) npc = bt;
            F_J:    npc = (pc4 & SEG_MASK) | (imm << 2);
            F_JAL: begin
                dest = REG_RA; val = pc4; wr = 1;
                npc = (pc4 & SEG_MASK) | (imm << 2);
            end
            F_PRELOAD: begin st_word(imm, pdata); npc = pc_q; end
            default: ;
        endcase
        if (wr && dest != REG_ZERO) gpr[dest] = val;
        else begin wr = 0; dest = 0; val = 0; end
        pc_q = npc;
        r.next_pc = npc;
        r.reg_write = wr;
        r.reg_number = dest;
        r.reg_value = val;
        r.hilo_write = hl;
        r.hi_value = hi_q;
        r.lo_value = lo_q;
        r.mem_read = mrd;
        r.mem_store = mst;
        r.mem_address = (mrd || mst) ? addr : 32'd0;
    endtask

    task automatic compare(input t_result e, input t_result g);
        if (g.next_pc !== e.next_pc) begin
            $error("next_pc expected %h got %h", e.next_pc, g.next_pc); o_mismatch_count++;
        end
        if (g.reg_write !== e.reg_write) begin
            $error("reg_write expected %0d got %0d", e.reg_write, g.reg_write); o_mismatch_count++;
        end
        if (g.reg_number !== e.reg_number) begin
            $error("reg_number expected %0d got %0d", e.reg_number, g.reg_number);
            o_mismatch_count++;
        end
        if (g.reg_value !== e.reg_value) begin
            $error("reg_value expected %h got %h", e.reg_value, g.reg_value); o_mismatch_count++;
        end
        if (g.hilo_write !== e.hilo_write) begin
            $error("hilo_write expected %0d got %0d", e.hilo_write, g.hilo_write);
            o_mismatch_count++;
        end
        if (g.hi_value !== e.hi_value) begin
            $error("hi_value expected %h got %h", e.hi_value, g.hi_value); o_mismatch_count++;
        end
        if (g.lo_value !== e.lo_value) begin
            $error("lo_value expected %h got %h", e.lo_value, g.lo_value); o_mismatch_count++;
        end
        if (g.mem_read !== e.mem_read) begin
            $error("mem_read expected %0d got %0d", e.mem_read, g.mem_read); o_mismatch_count++;
        end
        if (g.mem_store !== e.mem_store) begin
            $error("mem_store expected %0d got %0d", e.mem_store, g.mem_store); o_mismatch_count++;
        end
        if (g.mem_address !== e.mem_address) begin
            $error("mem_address expected %h got %h", e.mem_address, g.mem_address);
            o_mismatch_count++;
        end
    endtask

    initial begin
        o_mismatch_count = 0;
        o_result_count = 0;
    end

    assign o_waiting_count = expected_results.size();

    always @(posedge i_clk) begin
        t_result e, g;
        if (!i_rst_n) begin
            foreach (gpr[i]) gpr[i] = 0;
            gpr[REG_SP] = SP_RESET;
            hi_q = 0; lo_q = 0; pc_q = PC_RESET;
            foreach (dmem[i]) dmem[i] = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_START_PC) pc_q = i_cfg_data;
                else if (i_cfg_index == CFG_INIT_SP) gpr[REG_SP] = i_cfg_data;
            end
            if (i_m_tvalid && i_m_tready) begin
                o_result_count++;
                g.next_pc = i_m_tdata[31:0];
                g.reg_number = i_m_tdata[36:32];
                g.reg_value = i_m_tdata[68:37];
                g.hi_value = i_m_tdata[100:69];
                g.lo_value = i_m_tdata[132:101];
                g.mem_address = i_m_tdata[164:133];
                {g.mem_store, g.mem_read, g.hilo_write, g.reg_write} = i_m_tuser;
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding");
                    o_mismatch_count++;
                end else begin
                    e = expected_results.pop_front();
                    compare(e, g);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                execute(i_s_tdata, e);
                expected_results.push_back(e);
            end
        end
    end

endmodule

[test/mips_subset_execute_unit_tb.sv]
// testbench top for the mips subset execute unit: stimulus, watchdog and verdict
`timescale 1ns / 1ps
module mips_subset_execute_unit_tb;
    import mseu_pkg::*;

    localparam int HANG_LIMIT = 5000;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_s_tvalid = 0;
    logic         o_s_tready;
    logic [87:0]  i_s_tdata = 0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1;
    logic [167:0] o_m_tdata;
    logic [3:0]   o_m_tuser;
    logic         i_cfg_valid = 0;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index = 0;
    logic [31:0]  i_cfg_data = 0;

    int mismatch_count, waiting_count, result_count;
    int request_count = 0;
    int hang_cycles = 0;
    bit gaps_on = 1;

    always #6 i_clk = ~i_clk;

    mips_subset_execute_unit u_top (.*);

    mips_subset_execute_unit_chk u_chk (
        .i_clk, .i_rst_n,
        .i_s_tvalid, .i_s_tready(o_s_tready), .i_s_tdata,
        .i_m_tvalid(o_m_tvalid), .i_m_tready, .i_m_tdata(o_m_tdata), .i_m_tuser(o_m_tuser),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_mismatch_count(mismatch_count), .o_waiting_count(waiting_count),
        .o_result_count(result_count)
    );

    // watchdog: cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            hang_cycles <= 0;
        end else if (hang_cycles >= HANG_LIMIT) begin
            $display("mips_subset_execute_unit_tb failed");
            $finish;
        end else begin
            hang_cycles <= hang_cycles + 1;
        end
    end

    // result side backpressure in bursts
    initial begin
        forever begin
            i_m_tready <= 1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            if (gaps_on) begin
                i_m_tready <= 0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    end

    // one instruction request, valid is left high for a following request
    task automatic issue(input t_func f, input logic [4:0] rs, input logic [4:0] rt,
                         input logic [4:0] rd, input logic [31:0] imm,
                         input logic [31:0] pdata = 32'd0);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tdata <= {3'd0, pdata, imm, rd, rt, rs, f};
        do @(posedge i_clk); while (!o_s_tready);
        request_count++;
    endtask

    task automatic load_config(input logic [31:0] pc, input logic [31:0] sp);
        i_cfg_valid <= 1;
        i_cfg_index <= CFG_START_PC;
        i_cfg_data <= pc;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_INIT_SP;
        i_cfg_data <= sp;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
    endtask

    // drain all results, then idle before the next phase
    task automatic drain();
        i_s_tvalid <= 0;
        @(posedge i_clk);
        while (waiting_count != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_imm();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom_range(0, 128) - 64;
        endcase
    endfunction

    task automatic random_items(input int n);
        t_func f;
        repeat (n) begin
            if ($urandom_range(0, 19) == 0) f = t_func'($urandom_range(38, 63));
            else f = t_func'($urandom_range(0, 37));
            // mostly a handful of registers so results feed later requests
            if ($urandom_range(0, 3) != 0)
                issue(f, 5'($urandom_range(0, 7)), 5'($urandom_range(0, 7)),
                      5'($urandom_range(0, 7)), rand_imm(), $urandom);
            else
                issue(f, 5'($urandom), 5'($urandom), 5'($urandom), rand_imm(), $urandom);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        load_config(32'd0, 32'd1024);

        // directed: field extremes and corner cases
        issue(F_LUI, 0, 1, 0, 32'h0000_8000);
        issue(F_ORI, 1, 1, 0, 32'h0000_FFFF);
        issue(F_ADDI, 0, 2, 0, 32'h7FFF_FFFF);
        issue(F_ADD, 2, 2, 3, 0);                   // signed overflow wraps
        issue(F_SUB, 0, 2, 4, 0);
        issue(F_SRA, 0, 1, 5, 32'hFFFF_FFFF);       // shift amount low bits only
        issue(F_MULT, 1, 4, 0, 0);
        issue(F_MULTU, 1, 1, 0, 0);
        issue(F_MFHI, 0, 0, 6, 0);
        issue(F_MFLO, 0, 0, 0, 0);                  // write to zero dropped
        issue(F_PRELOAD, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue(F_LW, 0, 7, 0, 32'hFFFF_FFFE);
        issue(F_LB, 29, 0, 0, 32'hFFFF_FFFF);       // load into zero still reads
        issue(F_SW, 29, 0, 0, 32'hFFFF_FFFC);       // store of zero register
        issue(F_LH, 0, 8, 0, 32'h8000_03FE);
        issue(F_NAND, 1, 3, 9, 0);
        issue(F_NORI, 0, 10, 0, 32'h8000_0000);
        issue(F_SLTI, 3, 11, 0, 32'h7FFF_FFFF);
        issue(F_JAL, 0, 0, 0, 32'hFFFF_FFFF);
        issue(F_BGTZ, 2, 0, 0, 32'h8000_0000);
        issue(F_JR, 31, 0, 0, 0);
        issue(t_func'(6'd63), 31, 31, 31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        load_config(32'hFFFF_FFFC, 32'd0);
        random_items(250);
        drain();

        load_config($urandom, $urandom);
        random_items(250);
        drain();

        gaps_on = 0;
        load_config(32'h0FFF_FFF0, 32'hFFFF_FFFF);
        random_items(250);
        drain();

        $display("ran %0d instruction requests over four pc/sp settings, %0d results seen",
                 request_count, result_count);
        $display("every operation, unknown codes, memory wrap and backpressure included");
        if (mismatch_count == 0 && waiting_count == 0) begin
            $display("mips_subset_execute_unit_tb passed");
        end else begin
            $display("mips_subset_execute_unit_tb failed");
        end
        $finish;
    end

endmodule
